/* rtl/core/ttl_key_value_cache_top_assert.svh */
// Assertion macros shared by the key/value cache RTL.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef TTL_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define TTL_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TTL_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TTL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TTL_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define TTL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/ttl_kvc_pkg.sv */
// Package for the key/value cache: request codes, configuration indexes,
// the queued request type and default sizes. No dependencies.
package ttl_kvc_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Depth of the request queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam int REQ_W  = 3;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int NOW_W  = 47;
    localparam int EXP_W  = 48;
    localparam int TTL_W  = 32;
    localparam int CNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_PUT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TAKE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PURGE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

    localparam logic CFG_TTL     = 1'b0;
    localparam logic CFG_REFRESH = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [NOW_W-1:0] now;
        logic [EXP_W-1:0] expiry;   // expiry to store on put or refresh
        logic             refresh;  // a get hit restarts the lifetime
    } t_item;

endpackage

/* rtl/core/ttl_key_value_cache_top.sv */
// Top level of the key/value cache with time-to-live expiry.
// Depends on ttl_kvc_pkg, ttl_kvc_front, ttl_kvc_queue and ttl_kvc_back.
//
// Usage:
//   A request (req_type, key_tag, value_handle, now_ms) transfers at a rising
//   edge with i_start high and o_busy low. Its single result appears on
//   o_status, o_hit, o_value_out and o_entry_count for exactly one cycle,
//   marked by o_done; the receiver cannot stall, so it must take it then.
//   Configuration (ttl_ms at index 0, refresh_on_read at index 1) is written
//   with i_cfg_we while no request is outstanding.
// Pipeline and throughput:
//   A request is registered in the front stage, moves through a two-entry
//   queue and executes in the back end, whose result registers drive o_done;
//   one request per cycle is sustained while no purge is running.
//   A purge walks the slot table one slot per cycle; requests queue behind
//   it and o_busy rises once the front stage and queue are both full.
// Reset:
//   Synchronous, active low. The table is empty, both configuration
//   registers are zero and no result is pending.
module ttl_key_value_cache_top #(
    parameter int ENTRIES    = ttl_kvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = ttl_kvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = ttl_kvc_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [31:0]                   i_cfg_wdata,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [ttl_kvc_pkg::REQ_W-1:0] i_req_type,
    input  logic [ttl_kvc_pkg::KEY_W-1:0] i_key_tag,
    input  logic [ttl_kvc_pkg::VAL_W-1:0] i_value_handle,
    input  logic [ttl_kvc_pkg::NOW_W-1:0] i_now_ms,
    output logic                          o_done,
    output logic                          o_status,
    output logic                          o_hit,
    output logic [ttl_kvc_pkg::VAL_W-1:0] o_value_out,
    output logic [ttl_kvc_pkg::CNT_W-1:0] o_entry_count
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    ttl_kvc_pkg::t_item front_item;
    ttl_kvc_pkg::t_item head_item;

    ttl_kvc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_key_tag      (i_key_tag),
        .i_value_handle (i_value_handle),
        .i_now_ms       (i_now_ms),
        .o_push         (push),
        .o_item         (front_item),
        .i_full         (full)
    );

    ttl_kvc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_item)
    );

    ttl_kvc_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head_item),
        .o_pop         (pop),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_hit         (o_hit),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

endmodule

/* rtl/core/ttl_kvc_front.sv */
// Front part of the key/value cache: configuration registers, request
// intake and expiry computation. Depends on ttl_kvc_pkg.
module ttl_kvc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [31:0]                i_cfg_wdata,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [ttl_kvc_pkg::REQ_W-1:0] i_req_type,
    input  logic [ttl_kvc_pkg::KEY_W-1:0] i_key_tag,
    input  logic [ttl_kvc_pkg::VAL_W-1:0] i_value_handle,
    input  logic [ttl_kvc_pkg::NOW_W-1:0] i_now_ms,
    output logic                       o_push,
    output ttl_kvc_pkg::t_item         o_item,
    input  logic                       i_full
);

    logic [ttl_kvc_pkg::TTL_W-1:0] r_ttl;
    logic                          r_refresh;
    logic                          r_vld;
    ttl_kvc_pkg::t_item            r_item;
    ttl_kvc_pkg::t_item            n_item;
    logic                          accept;
    logic                          ttl_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl     <= '0;
            r_refresh <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttl_kvc_pkg::CFG_TTL:     r_ttl     <= i_cfg_wdata;
                ttl_kvc_pkg::CFG_REFRESH: r_refresh <= i_cfg_wdata[0];
                default:                  r_ttl     <= r_ttl;
            endcase
        end
    end

    assign o_busy = r_vld && i_full;
    assign accept = i_start && !o_busy;
    assign ttl_on = (r_ttl != '0);

    always_comb begin
        n_item.req     = i_req_type;
        n_item.key     = i_key_tag;
        n_item.val     = i_value_handle;
        n_item.now     = i_now_ms;
        // A zero lifetime stores expiry zero, which never expires.
        n_item.expiry  = ttl_on ? (ttl_kvc_pkg::EXP_W'(i_now_ms) + ttl_kvc_pkg::EXP_W'(r_ttl))
                                : '0;
        n_item.refresh = r_refresh && ttl_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_vld && !i_full;
    assign o_item = r_item;

endmodule

/* rtl/core/ttl_kvc_queue.sv */
// Short request queue between the front and back parts of the cache.
// Depends on ttl_kvc_pkg for the request type and depth.
module ttl_kvc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ttl_kvc_pkg::t_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output ttl_kvc_pkg::t_item o_head
);

    localparam int PW = $clog2(ttl_kvc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ttl_kvc_pkg::QUEUE_DEPTH + 1);

    ttl_kvc_pkg::t_item r_mem [ttl_kvc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      r_wp;
    logic [PW-1:0]      r_rp;
    logic [CW-1:0]      r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CW'(ttl_kvc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* rtl/core/ttl_kvc_back.sv */
// Back part of the cache: the associative slot table, request execution,
// the purge scan and the result registers. Depends on ttl_kvc_pkg and the
// assertion macro header.
`include "ttl_key_value_cache_top_assert.svh"

module ttl_kvc_back #(
    parameter int ENTRIES    = ttl_kvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = ttl_kvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = ttl_kvc_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  ttl_kvc_pkg::t_item            i_head,
    output logic                          o_pop,
    output logic                          o_done,
    output logic                          o_status,
    output logic                          o_hit,
    output logic [ttl_kvc_pkg::VAL_W-1:0] o_value_out,
    output logic [ttl_kvc_pkg::CNT_W-1:0] o_entry_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]              r_valid;
    logic [ENTRIES-1:0]              n_valid;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic [KEY_BITS-1:0]             r_key [ENTRIES];
    logic [VALUE_BITS-1:0]           r_val [ENTRIES];
    logic [ttl_kvc_pkg::EXP_W-1:0]   r_exp [ENTRIES];

    logic                            r_scan_act;
    logic                            n_scan_act;
    logic [IW-1:0]                   r_scan;
    logic [IW-1:0]                   n_scan;
    logic [ttl_kvc_pkg::NOW_W-1:0]   r_scan_now;

    logic                            r_done;
    logic                            r_status;
    logic                            r_hit;
    logic [ttl_kvc_pkg::VAL_W-1:0]   r_vout;
    logic                            n_done;
    logic                            n_status;
    logic                            n_hit;
    logic [ttl_kvc_pkg::VAL_W-1:0]   n_vout;

    logic [KEY_BITS-1:0]             key_in;
    logic [ttl_kvc_pkg::NOW_W-1:0]   cmp_now;
    logic [ENTRIES-1:0]              match;
    logic [ENTRIES-1:0]              expired;
    logic                            hit_any;
    logic                            free_any;
    logic [IW-1:0]                   hit_idx;
    logic [IW-1:0]                   free_idx;
    logic                            wr_en;
    logic [IW-1:0]                   wr_idx;
    logic                            exp_wr;

    assign key_in  = KEY_BITS'(i_head.key);
    assign cmp_now = r_scan_act ? r_scan_now : i_head.now;
    assign o_pop   = !i_empty && !r_scan_act;

    // Key match and expiry status of every slot, evaluated in parallel.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]   = r_valid[i] && (r_key[i] == key_in);
            expired[i] = (r_exp[i] != '0) &&
                         (r_exp[i] <= ttl_kvc_pkg::EXP_W'(cmp_now));
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    assign hit_any  = |match;
    assign free_any = ~&r_valid;

    always_comb begin
        n_valid    = r_valid;
        n_count    = r_count;
        n_scan_act = r_scan_act;
        n_scan     = r_scan;
        n_done     = 1'b0;
        n_status   = 1'b0;
        n_hit      = 1'b0;
        n_vout     = '0;
        wr_en      = 1'b0;
        wr_idx     = hit_idx;
        exp_wr     = 1'b0;
        if (r_scan_act) begin
            // Purge walks the table one slot per cycle.
            if (r_valid[r_scan] && expired[r_scan]) begin
                n_valid[r_scan] = 1'b0;
                n_count         = r_count - CW'(1);
            end
            n_scan = r_scan + IW'(1);
            if (r_scan == IW'(ENTRIES - 1)) begin
                n_scan_act = 1'b0;
                n_done     = 1'b1;
            end
        end else if (o_pop) begin
            n_done = 1'b1;
            unique case (i_head.req) inside
                ttl_kvc_pkg::REQ_PUT: begin
                    if (hit_any) begin
                        wr_en = 1'b1;
                    end else if (free_any) begin
                        wr_en             = 1'b1;
                        wr_idx            = free_idx;
                        n_valid[free_idx] = 1'b1;
                        n_count           = r_count + CW'(1);
                    end else begin
                        n_status = 1'b1;
                    end
                end
                ttl_kvc_pkg::REQ_GET, ttl_kvc_pkg::REQ_TAKE: begin
                    if (hit_any) begin
                        if (expired[hit_idx]) begin
                            n_valid[hit_idx] = 1'b0;
                            n_count          = r_count - CW'(1);
                        end else begin
                            n_hit  = 1'b1;
                            n_vout = ttl_kvc_pkg::VAL_W'(r_val[hit_idx]);
                            if (i_head.req == ttl_kvc_pkg::REQ_TAKE) begin
                                n_valid[hit_idx] = 1'b0;
                                n_count          = r_count - CW'(1);
                            end else begin
                                exp_wr = i_head.refresh;
                            end
                        end
                    end
                end
                ttl_kvc_pkg::REQ_REMOVE: begin
                    if (hit_any) begin
                        n_valid[hit_idx] = 1'b0;
                        n_count          = r_count - CW'(1);
                        n_hit            = 1'b1;
                    end
                end
                ttl_kvc_pkg::REQ_PURGE: begin
                    n_done     = 1'b0;
                    n_scan_act = 1'b1;
                    n_scan     = '0;
                end
                ttl_kvc_pkg::REQ_CLEAR: begin
                    n_valid = '0;
                    n_count = '0;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_count    <= '0;
            r_scan_act <= 1'b0;
            r_scan     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_scan_act <= n_scan_act;
            r_scan     <= n_scan;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hit    <= n_hit;
        r_vout   <= n_vout;
        if (o_pop) begin
            r_scan_now <= i_head.now;
        end
        if (wr_en) begin
            r_key[wr_idx] <= key_in;
            r_val[wr_idx] <= VALUE_BITS'(i_head.val);
            r_exp[wr_idx] <= i_head.expiry;
        end
        if (exp_wr) begin
            r_exp[hit_idx] <= i_head.expiry;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_hit         = r_hit;
    assign o_value_out   = r_vout;
    assign o_entry_count = ttl_kvc_pkg::CNT_W'(r_count);

    `TTL_ASSERT_ALWAYS(a_count_tracks_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_count), "occupied count differs from valid slots")
    `TTL_ASSERT_IMPL(a_full_only_when_all_valid, i_clk, i_rst_n, o_done && o_status, &r_valid, "full reported with a free slot")
    `TTL_ASSERT_IMPL(a_miss_has_zero_value, i_clk, i_rst_n, o_done && !o_hit, o_value_out == '0, "nonzero value on a miss")

endmodule

/* tb/tb_ttl_key_value_cache_top.sv */
// Self-checking testbench for ttl_key_value_cache_top: directed and random cache
// requests under several lifetime settings, checked against a behavioral table.
// Depends on ttl_kvc_pkg and the cache RTL.
`timescale 1ns / 1ps

module tb_ttl_key_value_cache_top;

    localparam int REQ_W          = ttl_kvc_pkg::REQ_W;
    localparam int KEY_W          = ttl_kvc_pkg::KEY_W;
    localparam int VAL_W          = ttl_kvc_pkg::VAL_W;
    localparam int NOW_W          = ttl_kvc_pkg::NOW_W;
    localparam int EXP_W          = ttl_kvc_pkg::EXP_W;
    localparam int TTL_W          = ttl_kvc_pkg::TTL_W;
    localparam int CNT_W          = ttl_kvc_pkg::CNT_W;

    localparam int SLOTS          = ttl_kvc_pkg::DEF_ENTRIES;
    localparam int KEY_POOL       = 22;
    localparam int SETTLE_CYCLES  = SLOTS + 8;
    // Longest quiet stretch in a good run is a sender pause plus a purge walk
    // or the settle at the end of a phase; this is far beyond that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Request codes that the block must treat as no operation.
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [NOW_W-1:0] now_ms;
    } t_cache_req;

    typedef struct packed {
        logic             status;
        logic             hit;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } t_cache_result;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic             i_cfg_idx      = 1'b0;
    logic [31:0]      i_cfg_wdata    = '0;
    logic             i_start        = 1'b0;
    logic [REQ_W-1:0] i_req_type     = '0;
    logic [KEY_W-1:0] i_key_tag      = '0;
    logic [VAL_W-1:0] i_value_handle = '0;
    logic [NOW_W-1:0] i_now_ms       = '0;
    logic             o_busy;
    logic             o_done;
    logic             o_status;
    logic             o_hit;
    logic [VAL_W-1:0] o_value_out;
    logic [CNT_W-1:0] o_entry_count;

    ttl_key_value_cache_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_key_tag      (i_key_tag),
        .i_value_handle (i_value_handle),
        .i_now_ms       (i_now_ms),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_value_out    (o_value_out),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioral copy of the table and its registers.
    logic             tbl_valid  [SLOTS];
    logic [KEY_W-1:0] tbl_key    [SLOTS];
    logic [VAL_W-1:0] tbl_value  [SLOTS];
    logic [EXP_W-1:0] tbl_expiry [SLOTS];
    int               tbl_count;
    logic [TTL_W-1:0] life_ms;
    logic             refresh_mode;

    t_cache_req       request_queue[$];
    t_cache_result    results_due[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [NOW_W-1:0] clock_ms;

    logic took_item       = 1'b0;
    bit   sender_pauses   = 1'b0;
    int   gap_left        = 0;
    int   quiet_cycles    = 0;
    int   mismatch_count  = 0;
    int   requests_sent   = 0;
    int   results_checked = 0;
    int   hits_seen       = 0;
    int   fulls_seen      = 0;
    int   settings_used   = 0;

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        int found;
        found = -1;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (tbl_valid[s] && tbl_key[s] == key) found = s;
        end
        return found;
    endfunction

    function automatic bit has_lapsed(input int s, input logic [NOW_W-1:0] now_ms);
        return tbl_expiry[s] != '0 && tbl_expiry[s] <= {1'b0, now_ms};
    endfunction

    function automatic void drop_entry(input int s);
        if (tbl_valid[s]) begin
            tbl_valid[s] = 1'b0;
            tbl_count--;
        end
    endfunction

    // Applies one request to the table and returns the answer it should give.
    function automatic t_cache_result apply_request(input t_cache_req rq);
        t_cache_result    res;
        int               slot;
        logic [EXP_W-1:0] life_end;
        res      = '0;
        life_end = (life_ms != '0) ? {1'b0, rq.now_ms} + {16'b0, life_ms} : '0;
        slot     = find_slot(rq.key);
        case (rq.req)
            ttl_kvc_pkg::REQ_PUT: begin
                if (slot < 0) begin
                    for (int s = SLOTS - 1; s >= 0; s--) begin
                        if (!tbl_valid[s]) slot = s;
                    end
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_count++;
                    end
                end
                if (slot < 0) begin
                    res.status = 1'b1;
                end else begin
                    tbl_key[slot]    = rq.key;
                    tbl_value[slot]  = rq.val;
                    tbl_expiry[slot] = life_end;
                end
            end
            ttl_kvc_pkg::REQ_GET, ttl_kvc_pkg::REQ_TAKE: begin
                if (slot >= 0) begin
                    if (has_lapsed(slot, rq.now_ms)) begin
                        drop_entry(slot);
                    end else begin
                        res.hit   = 1'b1;
                        res.value = tbl_value[slot];
                        if (rq.req == ttl_kvc_pkg::REQ_TAKE) begin
                            drop_entry(slot);
                        end else if (refresh_mode && life_ms != '0) begin
                            tbl_expiry[slot] = life_end;
                        end
                    end
                end
            end
            ttl_kvc_pkg::REQ_REMOVE: begin
                if (slot >= 0) begin
                    drop_entry(slot);
                    res.hit = 1'b1;
                end
            end
            ttl_kvc_pkg::REQ_PURGE: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (tbl_valid[s] && has_lapsed(s, rq.now_ms)) drop_entry(s);
                end
            end
            ttl_kvc_pkg::REQ_CLEAR: begin
                for (int s = 0; s < SLOTS; s++) drop_entry(s);
            end
            default: begin
            end
        endcase
        res.count = tbl_count[CNT_W-1:0];
        return res;
    endfunction

    function automatic void report_mismatch(input string why, input t_cache_result want,
                                            input t_cache_result seen);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: exp s=%0d h=%0d v=%h n=%0d, got s=%0d h=%0d v=%h n=%0d",
                     $realtime, why, want.status, want.hit, want.value, want.count,
                     seen.status, seen.hit, seen.value, seen.count);
        end
    endfunction

    // Driver: presents queued requests at the falling edge and holds each one
    // until it transfers.
    always @(negedge i_clk) begin
        t_cache_req next_req;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !took_item) begin
            // Request still waiting for the block to take it.
        end else if (gap_left != 0) begin
            gap_left = gap_left - 1;
            i_start <= 1'b0;
        end else if (request_queue.size() != 0) begin
            next_req = request_queue.pop_front();
            i_req_type     <= next_req.req;
            i_key_tag      <= next_req.key;
            i_value_handle <= next_req.val;
            i_now_ms       <= next_req.now_ms;
            i_start        <= 1'b1;
            if (sender_pauses && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 18);
        end else begin
            i_start <= 1'b0;
        end
    end

    // Monitor: predicts on each request transfer and checks each result strobe.
    always @(posedge i_clk) begin
        t_cache_result seen;
        t_cache_result want;
        bit            taken;
        taken = i_rst_n && i_start && (o_busy === 1'b0);
        took_item <= taken;
        if (i_rst_n) begin
            if (o_done !== 1'b0) begin
                seen = {o_status, o_hit, o_value_out, o_entry_count};
                results_checked++;
                if (results_due.size() == 0) begin
                    report_mismatch("result with none pending", '0, seen);
                end else begin
                    want = results_due.pop_front();
                    if (seen.status !== want.status || seen.hit !== want.hit ||
                        seen.value !== want.value || seen.count !== want.count) begin
                        report_mismatch("result mismatch", want, seen);
                    end
                    hits_seen  += want.hit;
                    fulls_seen += want.status;
                end
            end
            if (taken) begin
                results_due.push_back(apply_request({i_req_type, i_key_tag,
                                                     i_value_handle, i_now_ms}));
                requests_sent++;
            end
            if (taken || o_done === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ttl_kvc_pkg::CFG_TTL) begin
            life_ms = data;
        end else begin
            refresh_mode = data[0];
        end
    endtask

    task automatic program_registers(input logic [TTL_W-1:0] ttl, input logic refresh);
        write_reg(ttl_kvc_pkg::CFG_TTL, ttl);
        write_reg(ttl_kvc_pkg::CFG_REFRESH, {31'b0, refresh});
        settings_used++;
        @(posedge i_clk);
    endtask

    // Waits until every request has transferred and answered, then lets a
    // purge walk or any other back-end work run out.
    task automatic wait_idle();
        while (request_queue.size() != 0 || i_start || results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_req(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic [NOW_W-1:0] now_ms);
        request_queue.push_back('{req, key, val, now_ms});
    endtask

    task automatic refresh_key_pool();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < KEY_POOL; k++) key_pool[k] = {$urandom, $urandom};
    endtask

    // Random requests over a small key pool so the table fills, hits and
    // expires; wide_time draws every time stamp across the whole range.
    task automatic add_random_reqs(input int count, input int step_max, input bit wide_time);
        int               pick;
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [NOW_W-1:0] now_ms;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 36)      req = ttl_kvc_pkg::REQ_PUT;
            else if (pick < 60) req = ttl_kvc_pkg::REQ_GET;
            else if (pick < 70) req = ttl_kvc_pkg::REQ_TAKE;
            else if (pick < 80) req = ttl_kvc_pkg::REQ_REMOVE;
            else if (pick < 90) req = ttl_kvc_pkg::REQ_PURGE;
            else if (pick < 92) req = ttl_kvc_pkg::REQ_CLEAR;
            else if (pick < 96) req = REQ_RSVD6;
            else                req = REQ_RSVD7;
            if ($urandom_range(0, 9) == 0) begin
                key = {$urandom, $urandom};
            end else begin
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            end
            if (wide_time) begin
                now_ms = NOW_W'({$urandom, $urandom});
            end else begin
                clock_ms = clock_ms + NOW_W'($urandom_range(0, step_max));
                now_ms   = clock_ms;
            end
            add_req(req, key, $urandom, now_ms);
        end
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
        tbl_count    = 0;
        life_ms      = '0;
        refresh_mode = 1'b0;
        clock_ms     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill the table, overflow it, and walk through expiry at
        // the exact boundary, take, remove of a lapsed entry, purge and clear.
        program_registers(32'd100, 1'b0);
        refresh_key_pool();
        sender_pauses = 1'b1;
        add_req(ttl_kvc_pkg::REQ_PUT, key_pool[0], '1, '0);
        add_req(ttl_kvc_pkg::REQ_PUT, key_pool[1], '0, 47'd10);
        for (int k = 2; k < SLOTS; k++) begin
            add_req(ttl_kvc_pkg::REQ_PUT, key_pool[k], $urandom, 47'd10);
        end
        add_req(ttl_kvc_pkg::REQ_PUT, key_pool[SLOTS], $urandom, 47'd20);
        add_req(ttl_kvc_pkg::REQ_PUT, key_pool[0], 32'h5A5A_A5A5, 47'd20);
        add_req(ttl_kvc_pkg::REQ_GET, key_pool[0], $urandom, 47'd50);
        add_req(ttl_kvc_pkg::REQ_GET, key_pool[1], $urandom, 47'd110);
        add_req(ttl_kvc_pkg::REQ_TAKE, key_pool[2], $urandom, 47'd60);
        add_req(ttl_kvc_pkg::REQ_TAKE, key_pool[2], $urandom, 47'd60);
        add_req(ttl_kvc_pkg::REQ_REMOVE, key_pool[3], $urandom, 47'd500);
        add_req(ttl_kvc_pkg::REQ_REMOVE, key_pool[SLOTS], $urandom, 47'd500);
        add_req(REQ_RSVD6, key_pool[0], $urandom, 47'd60);
        add_req(REQ_RSVD7, key_pool[0], $urandom, 47'd60);
        add_req(ttl_kvc_pkg::REQ_PURGE, '0, '0, 47'd110);
        add_req(ttl_kvc_pkg::REQ_CLEAR, '0, '0, 47'd120);
        wait_idle();

        // Entries never expire; refresh has nothing to restart.
        program_registers('0, 1'b1);
        refresh_key_pool();
        add_random_reqs(100, 50, 1'b0);
        wait_idle();

        // Short lifetimes with refresh on read.
        program_registers($urandom_range(5, 60), 1'b1);
        refresh_key_pool();
        add_random_reqs(110, 10, 1'b0);
        wait_idle();

        // Arbitrary lifetime and time stamps, sender never pauses.
        sender_pauses = 1'b0;
        program_registers($urandom, 1'($urandom_range(0, 1)));
        refresh_key_pool();
        add_random_reqs(60, 0, 1'b1);
        add_random_reqs(60, 20, 1'b0);
        wait_idle();

        // Longest lifetime with the clock near the top of its range.
        sender_pauses = 1'b1;
        program_registers('1, 1'b1);
        refresh_key_pool();
        clock_ms = '1 - NOW_W'(2000);
        add_random_reqs(60, 20, 1'b0);
        add_random_reqs(30, 0, 1'b1);
        wait_idle();

        // One-millisecond lifetime, back-to-back requests to the end.
        sender_pauses = 1'b0;
        program_registers(32'd1, 1'b0);
        refresh_key_pool();
        clock_ms = '0;
        add_random_reqs(110, 2, 1'b0);
        wait_idle();

        $display("Sent %0d requests under %0d register settings; %0d results checked.",
                 requests_sent, settings_used, results_checked);
        $display("Saw %0d hits and %0d full-table puts; %0d mismatches, %0d results missing.",
                 hits_seen, fulls_seen, mismatch_count, results_due.size());
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
